@@ rtl/srsm_pkg.sv @@
// Shared types, widths and constants for the spiral rotate source mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srsm_pkg;

    localparam int COORD_W    = 13;  // signed offset from the destination center
    localparam int SQ_IN_W    = 32;  // radius-squared in Q.8, square root operand
    localparam int RAD_W      = 16;  // Q12.4 radius
    localparam int ISQ_STEPS  = 16;  // one result bit per stage
    localparam int ANG_W      = 16;  // binary angle, full turn = 65536
    localparam int CS_W       = 18;  // CORDIC x/y datapath
    localparam int Z_W        = 18;  // CORDIC residual angle
    localparam int TRIG_W     = 16;  // clamped Q1.14 sine/cosine
    localparam int CORDIC_STEPS = 14;

    localparam logic signed [CS_W-1:0] CORDIC_START = 18'sd9949;
    localparam logic signed [CS_W-1:0] Q14_ONE      = 18'sd16384;
    localparam logic signed [Z_W-1:0]  QUARTER_TURN = 18'sd16384;
    localparam logic signed [Z_W-1:0]  HALF_TURN    = 18'sd32768;

    // configuration register indexes
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEST_SIZE  = 3'd2;
    localparam logic [2:0] REG_ROT_ANGLE  = 3'd3;
    localparam logic [2:0] REG_SPIRAL_GAIN = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
    } coord_t;

    // arctangent of 2^-i in binary-angle units
    function automatic logic signed [Z_W-1:0] atan_val(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 18'sd8192;
            1:       v = 18'sd4836;
            2:       v = 18'sd2555;
            3:       v = 18'sd1297;
            4:       v = 18'sd651;
            5:       v = 18'sd326;
            6:       v = 18'sd163;
            7:       v = 18'sd81;
            8:       v = 18'sd41;
            9:       v = 18'sd20;
            10:      v = 18'sd10;
            11:      v = 18'sd5;
            12:      v = 18'sd3;
            13:      v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/srsm_isqrt.sv @@
// Pipelined restoring integer square root, one result bit per stage.
// Depends on srsm_pkg; carries the pixel offset alongside the operand.
`timescale 1ns / 1ps

module srsm_isqrt
    import srsm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [SQ_IN_W-1:0] in_val,
    input  coord_t             in_coord,
    output logic               out_valid,
    output logic [RAD_W-1:0]   out_radius,
    output coord_t             out_coord
);

    logic [SQ_IN_W-1:0] v_reg   [ISQ_STEPS];
    logic [SQ_IN_W-1:0] res_reg [ISQ_STEPS];
    coord_t             c_reg   [ISQ_STEPS];
    logic               vld_reg [ISQ_STEPS];

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
        localparam logic [SQ_IN_W-1:0] BIT_VAL = SQ_IN_W'(1) << (30 - 2 * k);
        logic [SQ_IN_W-1:0] v_in, r_in, trial, v_next, r_next;
        coord_t             c_in;
        logic               vl_in;

        if (k == 0) begin : g_first
            assign v_in  = in_val;
            assign r_in  = '0;
            assign c_in  = in_coord;
            assign vl_in = in_valid;
        end else begin : g_rest
            assign v_in  = v_reg[k-1];
            assign r_in  = res_reg[k-1];
            assign c_in  = c_reg[k-1];
            assign vl_in = vld_reg[k-1];
        end

        always_comb begin
            trial = r_in + BIT_VAL;
            if (v_in >= trial) begin
                v_next = v_in - trial;
                r_next = (r_in >> 1) + BIT_VAL;
            end else begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vl_in;
            end
            if (en) begin
                v_reg[k]   <= v_next;
                res_reg[k] <= r_next;
                c_reg[k]   <= c_in;
            end
        end
    end

    assign out_valid  = vld_reg[ISQ_STEPS-1];
    assign out_radius = res_reg[ISQ_STEPS-1][RAD_W-1:0];
    assign out_coord  = c_reg[ISQ_STEPS-1];

endmodule

@@ rtl/srsm_cordic.sv @@
// Pipelined rotation-mode CORDIC: quadrant fold, 14 micro-rotations, sign fix and clamp.
// Depends on srsm_pkg; carries the pixel offset alongside the angle.
`timescale 1ns / 1ps

module srsm_cordic
    import srsm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [ANG_W-1:0]         in_angle,
    input  coord_t                   in_coord,
    output logic                     out_valid,
    output logic signed [TRIG_W-1:0] out_sin,
    output logic signed [TRIG_W-1:0] out_cos,
    output coord_t                   out_coord
);

    // index 0 is the folded angle, 1..CORDIC_STEPS the rotations
    logic signed [CS_W-1:0] x_reg   [CORDIC_STEPS+1];
    logic signed [CS_W-1:0] y_reg   [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  z_reg   [CORDIC_STEPS+1];
    logic                   neg_reg [CORDIC_STEPS+1];
    coord_t                 c_reg   [CORDIC_STEPS+1];
    logic                   vld_reg [CORDIC_STEPS+1];

    logic signed [Z_W-1:0] z_raw, z_next;
    logic                  neg_next;

    always_comb begin
        z_raw    = Z_W'($signed(in_angle));
        z_next   = z_raw;
        neg_next = 1'b0;
        if (z_raw > QUARTER_TURN) begin
            z_next   = z_raw - HALF_TURN;
            neg_next = 1'b1;
        end else if (z_raw < -QUARTER_TURN) begin
            z_next   = z_raw + HALF_TURN;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            x_reg[0]   <= CORDIC_START;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
            c_reg[0]   <= in_coord;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam logic signed [Z_W-1:0] ATAN_I = atan_val(i);
        logic signed [CS_W-1:0] x_next, y_next;
        logic signed [Z_W-1:0]  zr_next;

        always_comb begin
            if (!z_reg[i][Z_W-1]) begin
                x_next  = x_reg[i] - (y_reg[i] >>> i);
                y_next  = y_reg[i] + (x_reg[i] >>> i);
                zr_next = z_reg[i] - ATAN_I;
            end else begin
                x_next  = x_reg[i] + (y_reg[i] >>> i);
                y_next  = y_reg[i] - (x_reg[i] >>> i);
                zr_next = z_reg[i] + ATAN_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= zr_next;
                neg_reg[i+1] <= neg_reg[i];
                c_reg[i+1]   <= c_reg[i];
            end
        end
    end

    logic signed [CS_W-1:0]   xs, ys;
    logic signed [TRIG_W-1:0] cos_next, sin_next;
    logic                     vld_out_reg;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    coord_t                   c_out_reg;

    always_comb begin
        xs = neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        ys = neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        if (xs > Q14_ONE)       cos_next = TRIG_W'(Q14_ONE);
        else if (xs < -Q14_ONE) cos_next = TRIG_W'(-Q14_ONE);
        else                    cos_next = TRIG_W'(xs);
        if (ys > Q14_ONE)       sin_next = TRIG_W'(Q14_ONE);
        else if (ys < -Q14_ONE) sin_next = TRIG_W'(-Q14_ONE);
        else                    sin_next = TRIG_W'(ys);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_out_reg <= vld_reg[CORDIC_STEPS];
        end
        if (en) begin
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
            c_out_reg <= c_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = vld_out_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;
    assign out_coord = c_out_reg;

endmodule

@@ rtl/spiral_rotate_source_mapper_top.sv @@
// Top level of the spiral rotate source mapper: config registers, front and back stages.
// Depends on srsm_pkg, srsm_isqrt and srsm_cordic.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one destination pixel per transfer, tdata = {dest_y, dest_x}.
//   Output stream (m_*): one result per input, in order, tdata = {inside_res,
//   src_address, src_y, src_x}; fields other than inside_res read zero when the
//   mapped point falls outside the source image.
//   Config port (cfg_*): index selects src_width, src_height, dest_size,
//   rotation_angle or spiral_gain (0..4); always ready. Write only when the
//   pipeline is empty; values take effect for every stage at once.
// Timing
//   Fully pipelined: one pixel per clock unless the output stalls. Stages:
//   offset, square, 16 square-root stages, twist multiply, angle add,
//   16 CORDIC stages (fold, 14 rotations, clamp), four coordinate products,
//   sums, truncating divide and recenter, bounds and address multiply, output.
// Flow control
//   All stages share one enable: the pipe moves whenever the output register
//   is empty or its result is being taken. When the receiver stalls with a
//   valid result the whole pipe freezes and s_tready drops; nothing is lost.
// Reset
//   aresetn (synchronous, active low) clears all valid bits and loads the
//   config defaults 256 / 256 / 362 / 0 / 0.

module spiral_rotate_source_mapper_top
    import srsm_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] dest_x, [21:11] dest_y, [23:22] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [10:0] src_x, [21:11] src_y, [43:22] src_address,
                                   // [44] inside_res, [47:45] zero
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [12:0] DIM_MAX = 13'(MAX_DIM);

    // ---------------- config registers ----------------
    logic [11:0] src_width_reg, src_height_reg, dest_size_reg;
    logic [15:0] rot_angle_reg, spiral_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg   <= 12'd256;
            src_height_reg  <= 12'd256;
            dest_size_reg   <= 12'd362;
            rot_angle_reg   <= '0;
            spiral_gain_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_WIDTH:   src_width_reg   <= cfg_data[11:0];
                REG_SRC_HEIGHT:  src_height_reg  <= cfg_data[11:0];
                REG_DEST_SIZE:   dest_size_reg   <= cfg_data[11:0];
                REG_ROT_ANGLE:   rot_angle_reg   <= cfg_data;
                REG_SPIRAL_GAIN: spiral_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions to MAX_DIM
    logic [12:0] sw_sat, sh_sat, ds_sat;
    assign sw_sat = ({1'b0, src_width_reg}  > DIM_MAX) ? DIM_MAX : {1'b0, src_width_reg};
    assign sh_sat = ({1'b0, src_height_reg} > DIM_MAX) ? DIM_MAX : {1'b0, src_height_reg};
    assign ds_sat = ({1'b0, dest_size_reg}  > DIM_MAX) ? DIM_MAX : {1'b0, dest_size_reg};

    // global pipe enable
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- A: offset from destination center ----------------
    logic   a_vld_reg;
    coord_t a_c_reg;
    coord_t a_c_next;

    always_comb begin
        a_c_next.tx = $signed({2'b0, s_tdata[10:0]}) - $signed({1'b0, ds_sat[12:1]});
        a_c_next.ty = $signed({2'b0, s_tdata[21:11]}) - $signed({1'b0, ds_sat[12:1]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en)  a_vld_reg <= s_tvalid;
        if (en) a_c_reg <= a_c_next;
    end

    // ---------------- B: radius squared ----------------
    logic        b_vld_reg;
    coord_t      b_c_reg;
    logic [23:0] b_r2_reg;
    logic signed [2*COORD_W-1:0] sq_x, sq_y;
    logic [23:0] b_r2_next;

    assign sq_x      = a_c_reg.tx * a_c_reg.tx;
    assign sq_y      = a_c_reg.ty * a_c_reg.ty;
    assign b_r2_next = 24'(sq_x) + 24'(sq_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) b_vld_reg <= 1'b0;
        else if (en)  b_vld_reg <= a_vld_reg;
        if (en) begin
            b_r2_reg <= b_r2_next;
            b_c_reg  <= a_c_reg;
        end
    end

    // ---------------- square root (Q12.4 radius) ----------------
    logic             q_vld;
    logic [RAD_W-1:0] q_radius;
    coord_t           q_c;

    srsm_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_vld_reg),
        .in_val    ({b_r2_reg, 8'b0}),
        .in_coord  (b_c_reg),
        .out_valid (q_vld),
        .out_radius(q_radius),
        .out_coord (q_c)
    );

    // ---------------- C: twist product ----------------
    logic        c_vld_reg;
    coord_t      c_c_reg;
    logic [31:0] c_twist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) c_vld_reg <= 1'b0;
        else if (en)  c_vld_reg <= q_vld;
        if (en) begin
            c_twist_reg <= spiral_gain_reg * q_radius;
            c_c_reg     <= q_c;
        end
    end

    // ---------------- D: angle ----------------
    logic             d_vld_reg;
    coord_t           d_c_reg;
    logic [ANG_W-1:0] d_angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) d_vld_reg <= 1'b0;
        else if (en)  d_vld_reg <= c_vld_reg;
        if (en) begin
            d_angle_reg <= rot_angle_reg + c_twist_reg[27:12];
            d_c_reg     <= c_c_reg;
        end
    end

    // ---------------- sine / cosine ----------------
    logic                     t_vld;
    logic signed [TRIG_W-1:0] t_sin, t_cos;
    coord_t                   t_c;

    srsm_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (d_vld_reg),
        .in_angle (d_angle_reg),
        .in_coord (d_c_reg),
        .out_valid(t_vld),
        .out_sin  (t_sin),
        .out_cos  (t_cos),
        .out_coord(t_c)
    );

    // ---------------- E: coordinate products ----------------
    localparam int PROD_W = COORD_W + TRIG_W;
    logic                     e_vld_reg;
    logic signed [PROD_W-1:0] e_xc_reg, e_ys_reg, e_yc_reg, e_xs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) e_vld_reg <= 1'b0;
        else if (en)  e_vld_reg <= t_vld;
        if (en) begin
            e_xc_reg <= t_c.tx * t_cos;
            e_ys_reg <= t_c.ty * t_sin;
            e_yc_reg <= t_c.ty * t_cos;
            e_xs_reg <= t_c.tx * t_sin;
        end
    end

    // ---------------- F: rotated sums ----------------
    logic                     f_vld_reg;
    logic signed [PROD_W:0]   f_nx_reg, f_ny_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) f_vld_reg <= 1'b0;
        else if (en)  f_vld_reg <= e_vld_reg;
        if (en) begin
            f_nx_reg <= (PROD_W+1)'(e_xc_reg) + (PROD_W+1)'(e_ys_reg);
            f_ny_reg <= (PROD_W+1)'(e_yc_reg) - (PROD_W+1)'(e_xs_reg);
        end
    end

    // ---------------- G: truncating divide by 2^14, recenter ----------------
    localparam logic signed [PROD_W:0] DIV_BIAS = (PROD_W+1)'(16383);
    logic                  g_vld_reg;
    logic signed [15:0]    g_sx_reg, g_sy_reg;
    logic signed [PROD_W:0] adj_x, adj_y;
    logic signed [15:0]    qx, qy;

    always_comb begin
        adj_x = f_nx_reg + (f_nx_reg[PROD_W] ? DIV_BIAS : '0);
        adj_y = f_ny_reg + (f_ny_reg[PROD_W] ? DIV_BIAS : '0);
        qx    = 16'(adj_x >>> 14);
        qy    = 16'(adj_y >>> 14);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) g_vld_reg <= 1'b0;
        else if (en)  g_vld_reg <= f_vld_reg;
        if (en) begin
            g_sx_reg <= qx + $signed({4'b0, sw_sat[12:1]});
            g_sy_reg <= qy + $signed({4'b0, sh_sat[12:1]});
        end
    end

    // ---------------- H: bounds and row offset ----------------
    logic        h_vld_reg, h_in_reg;
    logic [12:0] h_sx_reg, h_sy_reg;
    logic [25:0] h_row_reg;
    logic        in_next;

    assign in_next = !g_sx_reg[15] && !g_sy_reg[15]
                  && (unsigned'(g_sx_reg) < {3'b0, sw_sat})
                  && (unsigned'(g_sy_reg) < {3'b0, sh_sat});

    always_ff @(posedge aclk) begin
        if (!aresetn) h_vld_reg <= 1'b0;
        else if (en)  h_vld_reg <= g_vld_reg;
        if (en) begin
            h_in_reg  <= in_next;
            h_sx_reg  <= g_sx_reg[12:0];
            h_sy_reg  <= g_sy_reg[12:0];
            h_row_reg <= g_sy_reg[12:0] * sw_sat;
        end
    end

    // ---------------- I: output register ----------------
    logic        m_vld_reg, m_in_reg;
    logic [10:0] m_x_reg, m_y_reg;
    logic [21:0] m_addr_reg;
    logic [25:0] addr_full;

    assign addr_full = h_row_reg + {13'b0, h_sx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) m_vld_reg <= 1'b0;
        else if (en)  m_vld_reg <= h_vld_reg;
        if (en) begin
            m_in_reg   <= h_in_reg;
            m_x_reg    <= h_in_reg ? h_sx_reg[10:0]   : '0;
            m_y_reg    <= h_in_reg ? h_sy_reg[10:0]   : '0;
            m_addr_reg <= h_in_reg ? addr_full[21:0] : '0;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {3'b0, m_in_reg, m_addr_reg, m_y_reg, m_x_reg};

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_in_reg |-> m_x_reg == '0 && m_y_reg == '0 && m_addr_reg == '0)
        else $error("outside result carries nonzero fields");

    a_inside_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_in_reg |-> {2'b0, m_x_reg} < sw_sat && {2'b0, m_y_reg} < sh_sat)
        else $error("inside result beyond source bounds");

    a_addr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_in_reg |->
            m_addr_reg == 22'(m_y_reg * sw_sat + {13'b0, m_x_reg}))
        else $error("source address does not match coordinates");
`endif

endmodule
